// ----- hw/rtl/cds_pkg.sv -----
package cds_pkg;

    typedef logic [1:0]  t_func;
    typedef logic [1:0]  t_status;
    typedef logic [13:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_day;

    localparam t_func FN_NEXT_DAY   = 2'd0;
    localparam t_func FN_PREV_DAY   = 2'd1;
    localparam t_func FN_NEXT_MONTH = 2'd2;
    localparam t_func FN_PREV_MONTH = 2'd3;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_BAD_DATE   = 2'd1;
    localparam t_status ST_YEAR_RANGE = 2'd2;

    localparam t_year  YEAR_MAX  = 14'd9999;
    localparam t_month MONTH_JAN = 4'd1;
    localparam t_month MONTH_FEB = 4'd2;
    localparam t_month MONTH_DEC = 4'd12;

    // floor(y / 100) by reciprocal: 5243 / 2^19, exact for all 14-bit y
    function automatic logic [7:0] f_div100(input t_year y);
        logic [26:0] prod;
        prod = 27'(y) * 27'd5243;
        return prod[26:19];
    endfunction

    function automatic logic f_is_leap(input t_year y);
        logic [7:0]  q;
        logic [13:0] r;
        q = f_div100(y);
        r = y - 14'(q) * 14'd100;
        return ((y[1:0] == 2'b00) && (r != 14'd0)) || ((r == 14'd0) && (q[1:0] == 2'b00));
    endfunction

    function automatic t_day f_month_len(input t_month m, input logic leap);
        t_day len;
        case (m) inside
            4'd2:                                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                  len = 5'd31;
            default:                                len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 with mm = month shifted so March is 1
    function automatic logic [4:0] f_month_off(input t_month m);
        logic [4:0] v;
        case (m)
            4'd1:    v = 5'd28;
            4'd2:    v = 5'd31;
            4'd3:    v = 5'd2;
            4'd4:    v = 5'd5;
            4'd5:    v = 5'd7;
            4'd6:    v = 5'd10;
            4'd7:    v = 5'd12;
            4'd8:    v = 5'd15;
            4'd9:    v = 5'd18;
            4'd10:   v = 5'd20;
            4'd11:   v = 5'd23;
            4'd12:   v = 5'd25;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/calendar_date_step.sv -----
// Channel | Dir | Handshake                 | Payload
// input   | in  | i_in_valid / o_in_ready   | i_func, i_in_year, i_in_month, i_in_day
// output  | out | o_out_valid / i_out_ready | o_out_year/month/day, o_weekday, leap, len, status
//
// One transfer per cycle sustained while the output is not stalled; o_out_valid rises
// once the transfer has passed the input, step, calendar and result registers.
// Depth follows the chain: validate and step, weekday sum, sum modulo 7.
// i_rst_n (synchronous, active low) clears all stage valid bits only.
// A stalled output freezes the whole pipe; bubbles are squeezed out, so
// o_in_ready stays high while any stage is empty.
module calendar_date_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cds_pkg::t_func    i_func,
    input  cds_pkg::t_year    i_in_year,
    input  cds_pkg::t_month   i_in_month,
    input  cds_pkg::t_day     i_in_day,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cds_pkg::t_year    o_out_year,
    output cds_pkg::t_month   o_out_month,
    output cds_pkg::t_day     o_out_day,
    output logic [2:0]        o_weekday,
    output logic              o_leap_flag,
    output cds_pkg::t_day     o_month_length,
    output cds_pkg::t_status  o_status
);
    import cds_pkg::*;

    // stage enables, output end first
    logic en0, en1, en2, en3;
    logic r_v0, r_v1, r_v2, r_v3;

    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign o_in_ready  = en0;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_in_valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 0: input register ----------------
    t_func  r_s0_func;
    t_year  r_s0_year;
    t_month r_s0_month;
    t_day   r_s0_day;

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_s0_func  <= i_func;
            r_s0_year  <= i_in_year;
            r_s0_month <= i_in_month;
            r_s0_day   <= i_in_day;
        end
    end

    // ---------------- stage 1: validate and step ----------------
    // The year only changes across Dec/Jan (both 31 days), so the input
    // year's leap bit is right for every month length needed here,
    // including the clamp after a month step.
    logic    s1_leap, s1_bad, s1_range;
    t_day    s1_len_in, s1_len;
    t_year   n_s1_year;
    t_month  n_s1_month;
    t_day    n_s1_day;
    t_status n_s1_status;

    always_comb begin
        s1_leap   = f_is_leap(r_s0_year);
        s1_len_in = f_month_len(r_s0_month, s1_leap);
        s1_bad    = (r_s0_year == 14'd0) || (r_s0_year > YEAR_MAX) ||
                    (r_s0_month == 4'd0) || (r_s0_month > MONTH_DEC) ||
                    (r_s0_day == 5'd0) || (r_s0_day > s1_len_in);
        n_s1_year  = r_s0_year;
        n_s1_month = r_s0_month;
        n_s1_day   = r_s0_day;
        case (r_s0_func)
            FN_NEXT_DAY: begin
                if (r_s0_day == s1_len_in) begin
                    n_s1_day = 5'd1;
                    if (r_s0_month == MONTH_DEC) begin
                        n_s1_month = MONTH_JAN;
                        n_s1_year  = r_s0_year + 14'd1;
                    end else begin
                        n_s1_month = r_s0_month + 4'd1;
                    end
                end else begin
                    n_s1_day = r_s0_day + 5'd1;
                end
            end
            FN_PREV_DAY: begin
                if (r_s0_day == 5'd1) begin
                    if (r_s0_month == MONTH_JAN) begin
                        n_s1_month = MONTH_DEC;
                        n_s1_day   = 5'd31;
                        n_s1_year  = r_s0_year - 14'd1;
                    end else begin
                        n_s1_month = r_s0_month - 4'd1;
                        n_s1_day   = f_month_len(r_s0_month - 4'd1, s1_leap);
                    end
                end else begin
                    n_s1_day = r_s0_day - 5'd1;
                end
            end
            FN_NEXT_MONTH: begin
                if (r_s0_month == MONTH_DEC) begin
                    n_s1_month = MONTH_JAN;
                    n_s1_year  = r_s0_year + 14'd1;
                end else begin
                    n_s1_month = r_s0_month + 4'd1;
                end
            end
            default: begin
                if (r_s0_month == MONTH_JAN) begin
                    n_s1_month = MONTH_DEC;
                    n_s1_year  = r_s0_year - 14'd1;
                end else begin
                    n_s1_month = r_s0_month - 4'd1;
                end
            end
        endcase
        s1_len = f_month_len(n_s1_month, s1_leap);
        if (n_s1_day > s1_len) n_s1_day = s1_len;
        s1_range = (n_s1_year == 14'd0) || (n_s1_year > YEAR_MAX);
        if (s1_bad)        n_s1_status = ST_BAD_DATE;
        else if (s1_range) n_s1_status = ST_YEAR_RANGE;
        else               n_s1_status = ST_OK;
    end

    t_year   r_s1_year;
    t_month  r_s1_month;
    t_day    r_s1_day;
    t_day    r_s1_len;
    t_status r_s1_status;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_year   <= n_s1_year;
            r_s1_month  <= n_s1_month;
            r_s1_day    <= n_s1_day;
            r_s1_len    <= s1_len;
            r_s1_status <= n_s1_status;
        end
    end

    // ---------------- stage 2: leap bit and weekday sum ----------------
    // Zeller-style sum: Jan/Feb count as months 11/12 of the prior year.
    logic        s2_ok;
    logic        s2_early;
    t_year       s2_yy;
    logic [7:0]  s2_q100;
    logic [13:0] n_s2_sum;
    logic        n_s2_leap;

    always_comb begin
        s2_ok     = (r_s1_status == ST_OK);
        s2_early  = (r_s1_month <= MONTH_FEB);
        s2_yy     = r_s1_year - 14'(s2_early);
        s2_q100   = f_div100(s2_yy);
        n_s2_sum  = 14'(r_s1_day) + s2_yy + (s2_yy >> 2) - 14'(s2_q100)
                  + 14'(s2_q100 >> 2) + 14'(f_month_off(r_s1_month));
        n_s2_leap = f_is_leap(r_s1_year);
    end

    t_year       r_s2_year;
    t_month      r_s2_month;
    t_day        r_s2_day;
    t_day        r_s2_len;
    logic        r_s2_leap;
    logic [13:0] r_s2_sum;
    t_status     r_s2_status;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_year   <= s2_ok ? r_s1_year  : 14'd0;
            r_s2_month  <= s2_ok ? r_s1_month : 4'd0;
            r_s2_day    <= s2_ok ? r_s1_day   : 5'd0;
            r_s2_len    <= s2_ok ? r_s1_len   : 5'd0;
            r_s2_leap   <= s2_ok && n_s2_leap;
            r_s2_sum    <= s2_ok ? n_s2_sum   : 14'd0;
            r_s2_status <= r_s1_status;
        end
    end

    // ---------------- stage 3: sum mod 7 ----------------
    // quotient by 37450 / 2^18 (slightly above 1/7, exact below 2^14)
    logic [29:0] s3_prod;
    logic [11:0] s3_q7;
    logic [13:0] s3_rem;

    always_comb begin
        s3_prod = 30'(r_s2_sum) * 30'd37450;
        s3_q7   = s3_prod[29:18];
        s3_rem  = r_s2_sum - 14'(s3_q7) * 14'd7;
    end

    t_year      r_s3_year;
    t_month     r_s3_month;
    t_day       r_s3_day;
    logic [2:0] r_s3_wday;
    logic       r_s3_leap;
    t_day       r_s3_len;
    t_status    r_s3_status;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_year   <= r_s2_year;
            r_s3_month  <= r_s2_month;
            r_s3_day    <= r_s2_day;
            r_s3_wday   <= s3_rem[2:0];
            r_s3_leap   <= r_s2_leap;
            r_s3_len    <= r_s2_len;
            r_s3_status <= r_s2_status;
        end
    end

    assign o_out_year     = r_s3_year;
    assign o_out_month    = r_s3_month;
    assign o_out_day      = r_s3_day;
    assign o_weekday      = r_s3_wday;
    assign o_leap_flag    = r_s3_leap;
    assign o_month_length = r_s3_len;
    assign o_status       = r_s3_status;

endmodule

// ----- hw/rtl/cds_chk.sv -----
module cds_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input cds_pkg::t_year    o_out_year,
    input cds_pkg::t_month   o_out_month,
    input cds_pkg::t_day     o_out_day,
    input logic [2:0]        o_weekday,
    input logic              o_leap_flag,
    input cds_pkg::t_day     o_month_length,
    input cds_pkg::t_status  o_status
);
    import cds_pkg::*;

    // error results carry no date
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
        ((o_out_year == 14'd0) && (o_out_month == 4'd0) && (o_out_day == 5'd0) &&
         (o_weekday == 3'd0) && !o_leap_flag && (o_month_length == 5'd0)))
        else $error("nonzero fields on error status");

    // good results are real dates
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |->
        ((o_out_day >= 5'd1) && (o_out_day <= o_month_length) &&
         (o_out_month >= MONTH_JAN) && (o_out_month <= MONTH_DEC) &&
         (o_out_year >= 14'd1) && (o_out_year <= YEAR_MAX) && (o_weekday <= 3'd6)))
        else $error("result date out of range");

    // month length agrees with month and leap flag
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |->
        (o_month_length == f_month_len(o_out_month, o_leap_flag)))
        else $error("month length mismatch");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind calendar_date_step cds_chk u_cds_chk (.*);

// ----- sim/tb_top.sv -----
module tb_top;
    import cds_pkg::*;

    // One predicted result, plus the date that caused it for messages
    typedef struct packed {
        t_func      op;
        t_year      src_year;
        t_month     src_month;
        t_day       src_day;
        t_year      year;
        t_month     month;
        t_day       day;
        logic [2:0] wday;
        logic       leap;
        t_day       mlen;
        t_status    status;
    } t_cal_result;

    // ------------------------------------------------------------------
    // Date predictor and result scoreboard.
    // note_date() predicts the stepped date for an accepted input transfer.
    // check_result() compares an output transfer with the oldest prediction.
    // ------------------------------------------------------------------
    class cal_scoreboard;
        t_cal_result dates_due[$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_ok;
        int unsigned n_bad_date;
        int unsigned n_year_range;

        static function bit is_leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // caller guarantees month 1..12
        static function int unsigned month_days(int unsigned m, int unsigned y);
            if (m == MONTH_FEB)
                return is_leap_year(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // Zeller-style count with March as the first month; 0 = Sunday
        static function int unsigned day_of_week(int unsigned d, int unsigned m,
                                                 int unsigned y);
            int unsigned a;
            int unsigned yy;
            int unsigned mm;
            a  = (14 - m) / 12;
            yy = y - a;
            mm = m + 12 * a - 2;
            return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
        endfunction

        function t_cal_result step_date(t_func op, t_year y, t_month m, t_day d);
            t_cal_result r;
            int unsigned yr;
            int unsigned mo;
            int unsigned dy;
            int unsigned len;
            r = '0;
            r.op = op;
            r.src_year = y;
            r.src_month = m;
            r.src_day = d;
            if (y < 1 || y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC ||
                d < 1 || d > month_days(32'(m), 32'(y))) begin
                r.status = ST_BAD_DATE;
                return r;
            end
            yr = 32'(y);
            mo = 32'(m);
            dy = 32'(d);
            case (op)
                FN_NEXT_DAY: begin
                    if (dy == month_days(mo, yr)) begin
                        dy = 1;
                        if (mo == MONTH_DEC) begin
                            mo = MONTH_JAN;
                            yr++;
                        end else begin
                            mo++;
                        end
                    end else begin
                        dy++;
                    end
                end
                FN_PREV_DAY: begin
                    if (dy == 1) begin
                        if (mo == MONTH_JAN) begin
                            mo = MONTH_DEC;
                            dy = 31;
                            yr--;
                        end else begin
                            mo--;
                            dy = month_days(mo, yr);
                        end
                    end else begin
                        dy--;
                    end
                end
                FN_NEXT_MONTH: begin
                    if (mo == MONTH_DEC) begin
                        mo = MONTH_JAN;
                        yr++;
                    end else begin
                        mo++;
                    end
                end
                default: begin
                    if (mo == MONTH_JAN) begin
                        mo = MONTH_DEC;
                        yr--;
                    end else begin
                        mo--;
                    end
                end
            endcase
            // year 0 or 10000 after the step
            if (yr < 1 || yr > YEAR_MAX) begin
                r.status = ST_YEAR_RANGE;
                return r;
            end
            len = month_days(mo, yr);
            if (dy > len)
                dy = len;
            r.year   = t_year'(yr);
            r.month  = t_month'(mo);
            r.day    = t_day'(dy);
            r.wday   = 3'(day_of_week(dy, mo, yr));
            r.leap   = is_leap_year(yr);
            r.mlen   = t_day'(len);
            r.status = ST_OK;
            return r;
        endfunction

        function void note_date(t_func op, t_year y, t_month m, t_day d);
            t_cal_result r;
            r = step_date(op, y, m, d);
            case (r.status)
                ST_OK:       n_ok++;
                ST_BAD_DATE: n_bad_date++;
                default:     n_year_range++;
            endcase
            dates_due.push_back(r);
        endfunction

        function int pending();
            return dates_due.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < 100)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task cmp_field(t_cal_result w, string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("op %0d date %0d-%0d-%0d %s: got %0d, expected %0d",
                                          w.op, w.src_year, w.src_month, w.src_day,
                                          name, got, want));
        endtask

        task check_result(t_year y, t_month m, t_day d, logic [2:0] wd, logic lp,
                          t_day ml, t_status st);
            t_cal_result w;
            if (dates_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d status %0d",
                                          y, m, d, st));
                return;
            end
            w = dates_due.pop_front();
            n_checked++;
            cmp_field(w, "year", 32'(y), 32'(w.year));
            cmp_field(w, "month", 32'(m), 32'(w.month));
            cmp_field(w, "day", 32'(d), 32'(w.day));
            cmp_field(w, "weekday", 32'(wd), 32'(w.wday));
            cmp_field(w, "leap_flag", 32'(lp), 32'(w.leap));
            cmp_field(w, "month_length", 32'(ml), 32'(w.mlen));
            cmp_field(w, "status", 32'(st), 32'(w.status));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_func      i_func;
    t_year      i_in_year;
    t_month     i_in_month;
    t_day       i_in_day;
    logic       o_out_valid;
    logic       i_out_ready;
    t_year      o_out_year;
    t_month     o_out_month;
    t_day       o_out_day;
    logic [2:0] o_weekday;
    logic       o_leap_flag;
    t_day       o_month_length;
    t_status    o_status;

    calendar_date_step dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_in_year      (i_in_year),
        .i_in_month     (i_in_month),
        .i_in_day       (i_in_day),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_year     (o_out_year),
        .o_out_month    (o_out_month),
        .o_out_day      (o_out_day),
        .o_weekday      (o_weekday),
        .o_leap_flag    (o_leap_flag),
        .o_month_length (o_month_length),
        .o_status       (o_status)
    );

    cal_scoreboard sb;

    // steady: both sides stay busy with no idle cycles
    bit          steady = 1'b0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned stall_cycles = 0;

    localparam int unsigned RANDOM_ITEMS  = 1225;
    localparam int unsigned HOLD_AT       = 300;   // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned WATCHDOG_MAX  = 2000;
    localparam int unsigned DRAIN_CYCLES  = 8;     // pipe is four deep

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender tasks. All inputs change only with NBAs at a rising edge.
    // Valid stays up from one transfer to the next unless a gap is taken,
    // so it is never dropped and re-raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_date(t_func op, t_year y, t_month m, t_day d);
        if (!steady && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_in_year  <= y;
        i_in_month <= m;
        i_in_day   <= d;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // transfer took place at this edge
        sb.note_date(op, y, m, d);
    endtask

    // Well-formed date, biased toward year edges, century years and
    // first/last day of month so the carry paths get exercised.
    task automatic send_good_date();
        t_year       y;
        t_month      m;
        t_day        d;
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            y = t_year'($urandom_range(1, 3));
        else if (pick == 1)
            y = t_year'($urandom_range(9997, 9999));
        else if (pick == 2)
            y = t_year'($urandom_range(1, 99) * 100);
        else
            y = t_year'($urandom_range(1, 9999));
        m = t_month'($urandom_range(1, 12));
        len = cal_scoreboard::month_days(32'(m), 32'(y));
        pick = $urandom_range(0, 3);
        if (pick == 0)
            d = t_day'(len);
        else if (pick == 1)
            d = 5'd1;
        else
            d = t_day'($urandom_range(1, len));
        send_date(t_func'($urandom_range(0, 3)), y, m, d);
    endtask

    // Broken date: day just past month end, day zero, or bad month
    task automatic send_broken_date();
        t_year  y;
        t_month m;
        t_day   d;
        y = t_year'($urandom_range(1, 9999));
        m = t_month'($urandom_range(1, 12));
        case ($urandom_range(0, 2))
            0:       d = t_day'(cal_scoreboard::month_days(32'(m), 32'(y)) + 1);
            1:       d = 5'd0;
            default: begin
                m = ($urandom_range(0, 1) != 0) ? 4'd0 : t_month'($urandom_range(13, 15));
                d = t_day'($urandom_range(1, 31));
            end
        endcase
        send_date(t_func'($urandom_range(0, 3)), y, m, d);
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks each output transfer, then picks next ready.
    // Once, after HOLD_AT results, ready is held low for HOLD_CYCLES so
    // the pipe fills and o_in_ready must drop while the sender keeps going.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_year, o_out_month, o_out_day, o_weekday,
                                o_leap_flag, o_month_length, o_status);
                results_seen++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_MAX) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         stall_cycles, sb.pending());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned sel;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_func     <= FN_NEXT_DAY;
        i_in_year  <= '0;
        i_in_month <= '0;
        i_in_day   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes and invalid inputs
        send_date(FN_NEXT_DAY,   14'd0,     4'd1,  5'd1);    // year zero
        send_date(FN_NEXT_DAY,   14'h3FFF,  4'hF,  5'd31);   // all ones
        send_date(FN_PREV_DAY,   14'd10000, 4'd1,  5'd1);    // year past max
        send_date(FN_PREV_DAY,   14'd2024,  4'd0,  5'd10);   // month zero
        send_date(FN_NEXT_MONTH, 14'd2024,  4'd13, 5'd10);   // month 13
        send_date(FN_PREV_MONTH, 14'd2024,  4'd5,  5'd0);    // day zero
        send_date(FN_PREV_DAY,   14'd2024,  4'd4,  5'd31);   // past end of 30-day month
        // Leap rule on February 29
        send_date(FN_NEXT_DAY,   14'd2023,  MONTH_FEB, 5'd29); // plain year
        send_date(FN_NEXT_DAY,   14'd1900,  MONTH_FEB, 5'd29); // century, not leap
        send_date(FN_NEXT_DAY,   14'd2000,  MONTH_FEB, 5'd29); // 400-year leap
        send_date(FN_NEXT_DAY,   14'd2024,  MONTH_FEB, 5'd28);
        send_date(FN_PREV_DAY,   14'd2024,  4'd3,  5'd1);
        send_date(FN_PREV_DAY,   14'd2100,  4'd3,  5'd1);
        // Year carries
        send_date(FN_NEXT_DAY,   14'd2023,  MONTH_DEC, 5'd31);
        send_date(FN_PREV_DAY,   14'd2024,  MONTH_JAN, 5'd1);
        send_date(FN_NEXT_DAY,   YEAR_MAX,  MONTH_DEC, 5'd30);
        // Result year leaves 1..9999
        send_date(FN_NEXT_DAY,   YEAR_MAX,  MONTH_DEC, 5'd31);
        send_date(FN_PREV_DAY,   14'd1,     MONTH_JAN, 5'd1);
        send_date(FN_NEXT_MONTH, YEAR_MAX,  MONTH_DEC, 5'd15);
        send_date(FN_PREV_MONTH, 14'd1,     MONTH_JAN, 5'd31);
        // Month steps with day clamping
        send_date(FN_NEXT_MONTH, 14'd2024,  MONTH_JAN, 5'd31);
        send_date(FN_NEXT_MONTH, 14'd2023,  MONTH_JAN, 5'd31);
        send_date(FN_PREV_MONTH, 14'd2024,  4'd3,  5'd31);
        send_date(FN_NEXT_MONTH, 14'd2024,  MONTH_DEC, 5'd31);
        send_date(FN_PREV_MONTH, 14'd1,     MONTH_FEB, 5'd28);

        // Random: mostly valid dates, some broken ones, some raw noise.
        // A middle stretch runs with no idling on either side.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 500 && n < 800);
            sel = $urandom_range(0, 99);
            if (sel < 80)
                send_good_date();
            else if (sel < 88)
                send_broken_date();
            else
                send_date(t_func'($urandom_range(0, 3)), t_year'($urandom()),
                          t_month'($urandom()), t_day'($urandom()));
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        // Drain; the watchdog bounds this wait
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Stepped %0d dates: %0d valid, %0d bad input, %0d year out of range",
                 sb.n_ok + sb.n_bad_date + sb.n_year_range, sb.n_ok, sb.n_bad_date,
                 sb.n_year_range);
        $display("Checked %0d results with output back-pressure and input gaps, %0d mismatches",
                 sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
